### sv/spq_pkg.sv
// Package for the sorted priority queue: status codes, opcodes and the default capacity.
`timescale 1ns / 1ps
package spq_pkg;
    localparam int unsigned DefCapacity = 16;
    localparam logic [1:0] ST_PUSHED = 2'd0;
    localparam logic [1:0] ST_POPPED = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;
endpackage

### sv/sorted_priority_queue.sv
// Sorted priority queue top level: memory-held sorted list with a shifting sequencer.
//
// Input channel (valid/ready): op, item_value, item_priority. op 0 pushes, 1 pops.
// Output channel (valid/ready): status, out_value, out_priority, fill_level.
// One result transaction is given for every input transaction, in order.
// Entries live in one synchronous memory in ascending priority order; equal
// priorities leave in arrival order.
// A pop reads the head, then walks the list moving each entry down one slot.
// A push walks from the tail towards the head, moving larger entries up one
// slot, and writes the new entry into the gap.
// Each step is one memory read and at most one write, and the memory read is
// registered, so the time an operation takes grows with the number of entries
// it walks over; empty and full cases skip the walk.
// Reset clears the fill count and the sequencer; memory contents are not cleared.
// The result sits in an output register; while the receiver stalls the block
// holds it and accepts no new item until it has been taken.
`timescale 1ns / 1ps
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int unsigned CAPACITY = DefCapacity
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic signed [31:0] item_value,
    input  logic signed [31:0] item_priority,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic signed [31:0] out_value,
    output logic signed [31:0] out_priority,
    output logic [4:0]         fill_level
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CapC = CW'(CAPACITY);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_WR   = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;
    localparam logic [2:0] S_HEAD = 3'd4;

    logic [63:0] mem [CAPACITY];
    logic [63:0] rdata_reg;
    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [63:0] wdata;

    logic [2:0]  state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic        op_reg, op_next;
    logic signed [31:0] val_reg, val_next, pri_reg, pri_next;
    logic [1:0]  st_reg, st_next;
    logic signed [31:0] ov_reg, ov_next, opr_reg, opr_next;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        op_next    = op_reg;
        val_next   = val_reg;
        pri_next   = pri_reg;
        st_next    = st_reg;
        ov_next    = ov_reg;
        opr_next   = opr_reg;
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = idx_reg[AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = op;
                    val_next = item_value;
                    pri_next = item_priority;
                    ov_next  = '0;
                    opr_next = '0;
                    if (op == OP_POP)
                    begin
                        if (count_reg == '0)
                        begin
                            st_next    = ST_EMPTY;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            st_next    = ST_POPPED;
                            idx_next   = '0;
                            state_next = S_RD;
                        end
                    end
                    else if (count_reg >= CapC)
                    begin
                        st_next    = ST_FULL;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        st_next = ST_PUSHED;
                        if (count_reg == '0)
                        begin
                            we         = 1'b1;
                            waddr      = '0;
                            wdata      = {item_value, item_priority};
                            count_next = count_reg + 1'b1;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            idx_next   = count_reg - 1'b1;
                            state_next = S_RD;
                        end
                    end
                end
            end
            S_RD:
                state_next = S_WR;
            S_WR:
            begin
                if (op_reg == OP_POP)
                begin
                    if (idx_reg == '0)
                    begin
                        ov_next  = rdata_reg[63:32];
                        opr_next = rdata_reg[31:0];
                    end
                    else
                    begin
                        we    = 1'b1;
                        waddr = AW'(idx_reg - 1'b1);
                        wdata = rdata_reg;
                    end
                    if (idx_reg + 1'b1 >= count_reg)
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    we = 1'b1;
                    if ($signed(rdata_reg[31:0]) > pri_reg)
                    begin
                        waddr = AW'(idx_reg + 1'b1);
                        wdata = rdata_reg;
                        if (idx_reg == '0)
                        begin
                            idx_next   = '0;
                            state_next = S_HEAD;
                        end
                        else
                        begin
                            idx_next   = idx_reg - 1'b1;
                            state_next = S_RD;
                        end
                    end
                    else
                    begin
                        waddr      = AW'(idx_reg + 1'b1);
                        wdata      = {val_reg, pri_reg};
                        count_next = count_reg + 1'b1;
                        state_next = S_OUT;
                    end
                end
            end
            S_HEAD:
            begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = {val_reg, pri_reg};
                count_next = count_reg + 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
                if (out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        val_reg <= val_next;
        pri_reg <= pri_next;
        st_reg  <= st_next;
        ov_reg  <= ov_next;
        opr_reg <= opr_next;
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = (state_reg == S_OUT);
    assign status       = st_reg;
    assign out_value    = ov_reg;
    assign out_priority = opr_reg;
    assign fill_level   = 5'(count_reg);

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CapC)
        else $error("fill count beyond capacity");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(out_value)
            && $stable(out_priority) && $stable(fill_level)))
        else $error("result changed while stalled");
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && st_reg == ST_FULL) |-> count_reg == CapC)
        else $error("full status with room left");
`endif
endmodule
